>>> rtl/dts_pkg.sv
package dts_pkg;

    localparam int          CNT_W   = 14;
    localparam logic [13:0] CNT_MAX = 14'd16383;

    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_RW    = 2'd2;
    localparam logic [1:0] ACC_NONE  = 2'd3;

    localparam int REC_W = 24;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_UPD,
        S_STORE,
        S_INIT,
        S_WK_HEAD,
        S_WK_CUR,
        S_WK_MADDR,
        S_WK_MUPD,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic scan_rd;
        logic scan_cmp;
        logic scan_upd;
        logic store;
        logic init_step;
        logic wk_head;
        logic wk_cur;
        logic wk_maddr;
        logic wk_mupd;
        logic emit_rd;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic scan_done;
        logic match;
        logic rec_last;
        logic pc_zero;
        logic init_done;
        logic fifo_empty;
        logic nx_done;
        logic emit_last;
    } t_sts;

endpackage

>>> rtl/dts_ctrl.sv
module dts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  dts_pkg::t_sts i_sts,
    output dts_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    dts_pkg::t_state r_state;
    dts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dts_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dts_pkg::S_CLEAR: begin
                if (i_sts.clr_done) n_state = dts_pkg::S_IDLE;
            end
            dts_pkg::S_IDLE: begin
                if (i_in_valid) n_state = dts_pkg::S_SCAN_RD;
            end
            dts_pkg::S_SCAN_RD: begin
                if (!i_sts.is_read || i_sts.scan_done) n_state = dts_pkg::S_STORE;
                else n_state = dts_pkg::S_SCAN_CMP;
            end
            dts_pkg::S_SCAN_CMP: begin
                if (i_sts.match) n_state = dts_pkg::S_SCAN_UPD;
                else n_state = dts_pkg::S_SCAN_RD;
            end
            dts_pkg::S_SCAN_UPD: begin
                n_state = dts_pkg::S_SCAN_RD;
            end
            dts_pkg::S_STORE: begin
                if (i_sts.rec_last) n_state = dts_pkg::S_INIT;
                else n_state = dts_pkg::S_IDLE;
            end
            dts_pkg::S_INIT: begin
                if (i_sts.pc_zero) n_state = dts_pkg::S_CLEAR;
                else if (i_sts.init_done) n_state = dts_pkg::S_WK_HEAD;
            end
            dts_pkg::S_WK_HEAD: begin
                if (i_sts.fifo_empty) n_state = dts_pkg::S_EMIT_RD;
                else n_state = dts_pkg::S_WK_CUR;
            end
            dts_pkg::S_WK_CUR: begin
                n_state = dts_pkg::S_WK_MADDR;
            end
            dts_pkg::S_WK_MADDR: begin
                if (i_sts.nx_done) n_state = dts_pkg::S_WK_HEAD;
                else n_state = dts_pkg::S_WK_MUPD;
            end
            dts_pkg::S_WK_MUPD: begin
                n_state = dts_pkg::S_WK_MADDR;
            end
            dts_pkg::S_EMIT_RD: begin
                n_state = dts_pkg::S_EMIT_OUT;
            end
            dts_pkg::S_EMIT_OUT: begin
                if (!i_out_stall) begin
                    if (i_sts.emit_last) n_state = dts_pkg::S_CLEAR;
                    else n_state = dts_pkg::S_EMIT_RD;
                end
            end
            default: n_state = dts_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_in_stall      = 1'b1;
        o_out_valid     = 1'b0;
        case (r_state)
            dts_pkg::S_CLEAR: o_cmd.clear = 1'b1;
            dts_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            dts_pkg::S_SCAN_RD:  o_cmd.scan_rd = i_sts.is_read && !i_sts.scan_done;
            dts_pkg::S_SCAN_CMP: o_cmd.scan_cmp = 1'b1;
            dts_pkg::S_SCAN_UPD: o_cmd.scan_upd = 1'b1;
            dts_pkg::S_STORE:    o_cmd.store = 1'b1;
            dts_pkg::S_INIT:     o_cmd.init_step = !i_sts.init_done;
            dts_pkg::S_WK_HEAD:  o_cmd.wk_head = 1'b1;
            dts_pkg::S_WK_CUR:   o_cmd.wk_cur = 1'b1;
            dts_pkg::S_WK_MADDR: o_cmd.wk_maddr = !i_sts.nx_done;
            dts_pkg::S_WK_MUPD:  o_cmd.wk_mupd = 1'b1;
            dts_pkg::S_EMIT_RD:  o_cmd.emit_rd = 1'b1;
            dts_pkg::S_EMIT_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_next = !i_out_stall && !i_sts.emit_last;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

>>> rtl/dts_dp.sv
module dts_dp #(
    parameter int MAX_PASSES  = 32,
    parameter int MAX_RECORDS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dts_pkg::t_cmd i_cmd,
    output dts_pkg::t_sts o_sts,
    input  logic [4:0]    i_pass_index,
    input  logic          i_dep_valid,
    input  logic [1:0]    i_access,
    input  logic          i_is_texture,
    input  logic [15:0]   i_resource_id,
    input  logic          i_last,
    output logic [4:0]    o_sorted_pass,
    output logic [4:0]    o_order_position,
    output logic          o_cycle_error,
    output logic          o_last_result
);

    localparam int PW    = $clog2(MAX_PASSES);
    localparam int PCW   = $clog2(MAX_PASSES + 1);
    localparam int RAW   = $clog2(MAX_RECORDS);
    localparam int RCW   = $clog2(MAX_RECORDS + 1);
    localparam int DEPTH = MAX_PASSES * MAX_PASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = dts_pkg::CNT_W;

    logic [4:0]  r_p;
    logic        r_dv;
    logic [1:0]  r_acc;
    logic        r_tex;
    logic [15:0] r_id;
    logic        r_last;
    logic        r_inr;

    logic [RCW-1:0] r_rc;
    logic [RCW-1:0] r_k;
    logic [PCW-1:0] r_pc;
    logic [PCW-1:0] r_j;
    logic [PCW-1:0] r_head;
    logic [PCW-1:0] r_tail;
    logic [PW-1:0]  r_cur;
    logic [AW-1:0]  r_clr;
    logic [AW-1:0]  r_maddr;
    logic [CW-1:0]  r_indeg [MAX_PASSES];

    logic [dts_pkg::REC_W-1:0] r_rec_mem [MAX_RECORDS];
    logic [dts_pkg::REC_W-1:0] r_rec_q;
    logic [CW-1:0]             r_mult_mem [DEPTH];
    logic [CW-1:0]             r_m_q;
    logic [PW-1:0]             r_fifo_mem [MAX_PASSES];
    logic [PW-1:0]             r_f_q;

    logic           i_inr;
    logic           rec_ok;
    logic [4:0]     q;
    logic [1:0]     ra;
    logic           match;
    logic [PW-1:0]  p_idx;
    logic [PW-1:0]  j_idx;
    logic [AW-1:0]  scan_addr;
    logic [AW-1:0]  walk_addr;
    logic [CW-1:0]  d;
    logic [CW-1:0]  nd;
    logic           wk_hit;
    logic           init_push;
    logic           err;
    logic [PCW:0]   j_next;

    assign i_inr  = 32'(i_pass_index) < MAX_PASSES;
    assign rec_ok = r_inr && r_dv && (r_acc != dts_pkg::ACC_NONE);
    assign q      = r_rec_q[23:19];
    assign ra     = r_rec_q[18:17];
    assign match  = (q < r_p) && (ra == dts_pkg::ACC_WRITE || ra == dts_pkg::ACC_RW)
                    && (r_rec_q[16] == r_tex) && (r_rec_q[15:0] == r_id);
    assign p_idx  = PW'(r_p);
    assign j_idx  = r_j[PW-1:0];
    assign scan_addr = AW'(32'(q) * MAX_PASSES + 32'(r_p));
    assign walk_addr = AW'(32'(r_cur) * MAX_PASSES + 32'(r_j));
    assign d      = r_indeg[j_idx];
    assign nd     = (d > r_m_q) ? d - r_m_q : '0;
    assign wk_hit = (r_m_q != '0) && (d != '0);
    assign init_push = i_cmd.init_step && (d == '0);
    assign err    = r_head != r_pc;
    assign j_next = (PCW + 1)'(r_j) + (PCW + 1)'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.clr_done   = r_clr == AW'(DEPTH - 1);
        o_sts.is_read    = rec_ok && (r_acc == dts_pkg::ACC_READ || r_acc == dts_pkg::ACC_RW);
        o_sts.scan_done  = r_k == r_rc;
        o_sts.match      = match;
        o_sts.rec_last   = r_last;
        o_sts.pc_zero    = r_pc == '0;
        o_sts.init_done  = r_j == r_pc;
        o_sts.fifo_empty = r_head == r_tail;
        o_sts.nx_done    = r_j == r_pc;
        o_sts.emit_last  = err || (j_next == (PCW + 1)'(r_head));
    end

    assign o_sorted_pass    = err ? 5'd0 : 5'(r_f_q);
    assign o_order_position = err ? 5'd0 : 5'(r_j);
    assign o_cycle_error    = err;
    assign o_last_result    = o_sts.emit_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p    <= i_pass_index;
            r_dv   <= i_dep_valid;
            r_acc  <= i_access;
            r_tex  <= i_is_texture;
            r_id   <= i_resource_id;
            r_last <= i_last;
            r_inr  <= i_inr;
        end
        if (i_cmd.wk_cur) begin
            r_cur <= r_f_q;
        end
        if (i_cmd.scan_cmp) begin
            r_maddr <= scan_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc   <= '0;
            r_k    <= '0;
            r_pc   <= '0;
            r_j    <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_clr  <= '0;
            for (int i = 0; i < MAX_PASSES; i++) begin
                r_indeg[i] <= '0;
            end
        end else begin
            if (i_cmd.clear) begin
                r_rc   <= '0;
                r_pc   <= '0;
                r_head <= '0;
                r_tail <= '0;
                r_clr  <= o_sts.clr_done ? '0 : r_clr + AW'(1);
                for (int i = 0; i < MAX_PASSES; i++) begin
                    r_indeg[i] <= '0;
                end
            end
            if (i_cmd.accept) begin
                r_k <= '0;
                if (i_inr && (PCW'(i_pass_index) + PCW'(1) > r_pc)) begin
                    r_pc <= PCW'(i_pass_index) + PCW'(1);
                end
            end
            if ((i_cmd.scan_cmp && !match) || i_cmd.scan_upd) begin
                r_k <= r_k + RCW'(1);
            end
            if (i_cmd.scan_upd && r_indeg[p_idx] < dts_pkg::CNT_MAX) begin
                r_indeg[p_idx] <= r_indeg[p_idx] + CW'(1);
            end
            if (i_cmd.store) begin
                r_j <= '0;
                if (rec_ok && 32'(r_rc) < MAX_RECORDS) begin
                    r_rc <= r_rc + RCW'(1);
                end
            end
            if (i_cmd.init_step) begin
                r_j <= r_j + PCW'(1);
                if (init_push) begin
                    r_tail <= r_tail + PCW'(1);
                end
            end
            if (i_cmd.wk_head) begin
                r_j <= '0;
                if (r_head != r_tail) begin
                    r_head <= r_head + PCW'(1);
                end
            end
            if (i_cmd.wk_cur) begin
                r_j <= '0;
            end
            if (i_cmd.wk_mupd) begin
                r_j <= r_j + PCW'(1);
                if (wk_hit) begin
                    r_indeg[j_idx] <= nd;
                    if (nd == '0) begin
                        r_tail <= r_tail + PCW'(1);
                    end
                end
            end
            if (i_cmd.emit_next) begin
                r_j <= r_j + PCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && rec_ok && 32'(r_rc) < MAX_RECORDS) begin
            r_rec_mem[r_rc[RAW-1:0]] <= {r_p, r_acc, r_tex, r_id};
        end
        if (i_cmd.scan_rd) begin
            r_rec_q <= r_rec_mem[r_k[RAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mult_mem[r_clr] <= '0;
        end else if (i_cmd.scan_upd) begin
            r_mult_mem[r_maddr] <= (r_m_q < dts_pkg::CNT_MAX) ? r_m_q + CW'(1) : r_m_q;
        end
        if (i_cmd.scan_cmp) begin
            r_m_q <= r_mult_mem[scan_addr];
        end else if (i_cmd.wk_maddr) begin
            r_m_q <= r_mult_mem[walk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (init_push || (i_cmd.wk_mupd && wk_hit && nd == '0)) begin
            r_fifo_mem[r_tail[PW-1:0]] <= j_idx;
        end
        if (i_cmd.wk_head && r_head != r_tail) begin
            r_f_q <= r_fifo_mem[r_head[PW-1:0]];
        end else if (i_cmd.emit_rd) begin
            r_f_q <= r_fifo_mem[j_idx];
        end
    end

endmodule

>>> rtl/dependency_topological_sort.sv
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    pass_index, dep_valid, access, is_texture,
//                                                resource_id, last
// out      output     o_out_valid / i_out_stall  sorted_pass, order_position, cycle_error,
//                                                last_result
// A record that reads is compared against every stored record, and each matching writer adds
// to the edge count; a valid record is then stored while room remains.
// The last record starts the queue seeding, then the walk over the edge-count memory row of
// each dequeued pass, then the results one by one, and then a clear of that memory.
// After reset the edge-count memory is cleared with o_in_stall high.
// A stalled result holds until taken; no new record is taken until the sort is delivered.
module dependency_topological_sort #(
    parameter int MAX_PASSES  = 32,
    parameter int MAX_RECORDS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [4:0]  i_pass_index,
    input  logic        i_dep_valid,
    input  logic [1:0]  i_access,
    input  logic        i_is_texture,
    input  logic [15:0] i_resource_id,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_sorted_pass,
    output logic [4:0]  o_order_position,
    output logic        o_cycle_error,
    output logic        o_last_result
);

    dts_pkg::t_cmd cmd;
    dts_pkg::t_sts sts;

    dts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    dts_dp #(
        .MAX_PASSES  (MAX_PASSES),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_pass_index     (i_pass_index),
        .i_dep_valid      (i_dep_valid),
        .i_access         (i_access),
        .i_is_texture     (i_is_texture),
        .i_resource_id    (i_resource_id),
        .i_last           (i_last),
        .o_sorted_pass    (o_sorted_pass),
        .o_order_position (o_order_position),
        .o_cycle_error    (o_cycle_error),
        .o_last_result    (o_last_result)
    );

endmodule
